>>> rtl/dnd_pkg.sv
// Shared types and constants for the DNS name decompressor.
package dnd_pkg;

  localparam int unsigned PACKET_BYTES_DEF = 512;
  localparam int unsigned MAX_NAME_LEN     = 254;

  localparam logic       OP_LOAD   = 1'b0;
  localparam logic       OP_PARSE  = 1'b1;
  localparam logic [1:0] LABEL_TAG = 2'b00;
  localparam logic [1:0] PTR_TAG   = 2'b11;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_LONG  = 3'd1,
    ST_TRUNC = 3'd2,
    ST_LOOP  = 3'd3,
    ST_RESV  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_COPY,
    S_PTR,
    S_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    start;
    logic    push;
    logic    advance;
    logic    label_begin;
    logic    ptr_begin;
    logic    ptr_jump;
    logic    set_status;
    status_e status;
    logic    flush;
    logic    emit_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       pos_lt_len;
    logic       byte_zero;
    logic [1:0] byte_tag;
    logic       too_long;
    logic       label_trunc;
    logic       ptr_trunc;
    logic       target_trunc;
    logic       loop;
    logic       fill_full;
    logic       out_free;
    logic       cnt_last;
  } sts_t;

endpackage

>>> rtl/dns_name_decompressor.sv
// Top level of the DNS name decompressor: controller plus datapath.
// A load word (op 0) writes one packet byte; first_byte restarts the packet at
// offset zero, and a byte loaded into a full store is dropped. A parse word
// (op 1) walks the name at start_offset through the packet store, one byte
// read per cycle while the output is not stalled: it accepts the word, reads
// each length byte, copies each label byte (the length byte included),
// follows each compression pointer by reading its high and then its low byte,
// moves each full 8-byte word to the output register and emits the final
// chunk. The expanded name leaves in 8-byte words, first byte in the lowest
// lane; a full word goes out as soon as it fills and the output register is
// free, and the word with last set carries the status and, when the status
// is ok, the offset just past the name (past the first pointer if one was
// followed). A finished word waits in an output register, so the next word
// can be accepted while the result is still pending. The store holds no
// defined value until written, but only bytes below the loaded length are
// ever used.
module dns_name_decompressor #(
  parameter int unsigned PACKET_BYTES = dnd_pkg::PACKET_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  packet_byte_i,
  input  logic        first_byte_i,
  input  logic [8:0]  start_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] name_chunk_o,
  output logic [3:0]  chunk_bytes_o,
  output logic        last_o,
  output logic [2:0]  status_o,
  output logic [9:0]  next_offset_o
);

  dnd_pkg::cmd_t cmd;
  dnd_pkg::sts_t sts;

  dnd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dnd_dp #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .packet_byte_i  (packet_byte_i),
    .first_byte_i   (first_byte_i),
    .start_offset_i (start_offset_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .name_chunk_o   (name_chunk_o),
    .chunk_bytes_o  (chunk_bytes_o),
    .last_o         (last_o),
    .status_o       (status_o),
    .next_offset_o  (next_offset_o)
  );

endmodule

>>> rtl/dnd_dp.sv
// Datapath: packet store, walk registers, chunk buffer and output register.
module dnd_dp #(
  parameter int unsigned PACKET_BYTES = dnd_pkg::PACKET_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dnd_pkg::cmd_t      cmd_i,
  output dnd_pkg::sts_t      sts_o,
  input  logic [7:0]         packet_byte_i,
  input  logic               first_byte_i,
  input  logic [8:0]         start_offset_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [63:0]        name_chunk_o,
  output logic [3:0]         chunk_bytes_o,
  output logic               last_o,
  output logic [2:0]         status_o,
  output logic [9:0]         next_offset_o
);

  localparam int unsigned AW = $clog2(PACKET_BYTES);
  localparam int unsigned LW = $clog2(PACKET_BYTES + 1);
  localparam int unsigned PW = (LW > 9) ? LW : 9;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned CW = (SW > 14) ? SW : 14;

  logic [7:0]       mem [PACKET_BYTES];
  logic [7:0]       rdata_q;
  logic [LW-1:0]    len_q, len_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [7:0]       name_len_q, name_len_d;
  logic [8:0]       prev_q, prev_d;
  logic             ptr_seen_q, ptr_seen_d;
  logic [PW-1:0]    ret_q, ret_d;
  logic [5:0]       hi_q, hi_d;
  logic [6:0]       cnt_q, cnt_d;
  logic [63:0]      chunk_q, chunk_d;
  logic [3:0]       fill_q, fill_d;
  dnd_pkg::status_e st_q, st_d;
  logic [9:0]       next_q, next_d;

  logic             out_valid_q, out_valid_d;
  logic [63:0]      out_chunk_q;
  logic [3:0]       out_bytes_q;
  logic             out_last_q;
  dnd_pkg::status_e out_status_q;
  logic [9:0]       out_next_q;

  logic [SW-1:0]    len_ext, pos_ext, pos_n_sum, pos_1_sum, pos_2_sum;
  logic [6:0]       label_n;
  logic [8:0]       name_sum;
  logic [13:0]      target;
  logic [LW-1:0]    wr_idx;
  logic             wr_en;
  logic             out_free;

  assign len_ext   = SW'(len_q);
  assign pos_ext   = SW'(pos_q);
  assign label_n   = 7'(rdata_q[5:0]) + 7'd1;
  assign pos_n_sum = pos_ext + SW'(label_n);
  assign pos_1_sum = pos_ext + SW'(1);
  assign pos_2_sum = pos_ext + SW'(2);
  assign name_sum  = 9'(name_len_q) + 9'(label_n);
  assign target    = {hi_q, rdata_q};
  assign out_free  = !out_valid_q || out_ready_i;

  assign wr_idx = first_byte_i ? '0 : len_q;
  assign wr_en  = cmd_i.load && (first_byte_i || (len_q < LW'(PACKET_BYTES)));

  always_comb begin
    sts_o              = '0;
    sts_o.pos_lt_len   = pos_ext < len_ext;
    sts_o.byte_zero    = rdata_q == 8'd0;
    sts_o.byte_tag     = rdata_q[7:6];
    sts_o.too_long     = name_sum > 9'(dnd_pkg::MAX_NAME_LEN);
    sts_o.label_trunc  = pos_n_sum > len_ext;
    sts_o.ptr_trunc    = pos_2_sum > len_ext;
    sts_o.target_trunc = CW'(target) > CW'(len_q);
    sts_o.loop         = prev_q == {1'b0, name_len_q};
    sts_o.fill_full    = fill_q == 4'd8;
    sts_o.out_free     = out_free;
    sts_o.cnt_last     = cnt_q == 7'd1;
  end

  always_comb begin
    len_d      = wr_en ? (wr_idx + LW'(1)) : len_q;
    pos_d      = pos_q;
    name_len_d = name_len_q;
    prev_d     = prev_q;
    ptr_seen_d = ptr_seen_q;
    ret_d      = ret_q;
    hi_d       = hi_q;
    cnt_d      = cnt_q;
    chunk_d    = chunk_q;
    fill_d     = fill_q;
    st_d       = st_q;
    next_d     = next_q;

    if (cmd_i.start) begin
      pos_d      = PW'(start_offset_i);
      name_len_d = 8'd0;
      prev_d     = 9'h1ff;
      ptr_seen_d = 1'b0;
      ret_d      = '0;
      chunk_d    = 64'd0;
      fill_d     = 4'd0;
    end
    if (cmd_i.advance) begin
      pos_d = PW'(pos_1_sum);
      cnt_d = cnt_q - 7'd1;
    end
    if (cmd_i.label_begin) begin
      cnt_d      = label_n;
      name_len_d = name_sum[7:0];
    end
    if (cmd_i.ptr_begin) begin
      pos_d = PW'(pos_1_sum);
      hi_d  = rdata_q[5:0];
      if (!ptr_seen_q) begin
        ptr_seen_d = 1'b1;
        ret_d      = PW'(pos_2_sum);
      end
    end
    if (cmd_i.ptr_jump) begin
      pos_d  = PW'(target);
      prev_d = {1'b0, name_len_q};
    end
    if (cmd_i.push) begin
      chunk_d[8*fill_q[2:0] +: 8] = rdata_q;
      fill_d = fill_q + 4'd1;
    end
    if (cmd_i.flush || cmd_i.emit_last) begin
      chunk_d = 64'd0;
      fill_d  = 4'd0;
    end
    if (cmd_i.set_status) begin
      st_d   = cmd_i.status;
      next_d = ptr_seen_q ? 10'(ret_q) : 10'(pos_1_sum);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.flush || cmd_i.emit_last) begin
      out_valid_d = 1'b1;
    end
  end

  // The store is read every cycle at the next walk position, so the read
  // data always holds the byte at the current position.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx[AW-1:0]] <= packet_byte_i;
    end
    rdata_q <= mem[pos_d[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      name_len_q  <= 8'd0;
      prev_q      <= 9'h1ff;
      ptr_seen_q  <= 1'b0;
      ret_q       <= '0;
      chunk_q     <= 64'd0;
      fill_q      <= 4'd0;
      cnt_q       <= 7'd0;
      st_q        <= dnd_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      name_len_q  <= name_len_d;
      prev_q      <= prev_d;
      ptr_seen_q  <= ptr_seen_d;
      ret_q       <= ret_d;
      chunk_q     <= chunk_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    hi_q   <= hi_d;
    next_q <= next_d;
    if (cmd_i.flush) begin
      out_chunk_q  <= chunk_q;
      out_bytes_q  <= 4'd8;
      out_last_q   <= 1'b0;
      out_status_q <= dnd_pkg::ST_OK;
      out_next_q   <= 10'd0;
    end else if (cmd_i.emit_last) begin
      out_chunk_q  <= chunk_q;
      out_bytes_q  <= fill_q;
      out_last_q   <= 1'b1;
      out_status_q <= st_q;
      out_next_q   <= (st_q == dnd_pkg::ST_OK) ? next_q : 10'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign name_chunk_o  = out_chunk_q;
  assign chunk_bytes_o = out_bytes_q;
  assign last_o        = out_last_q;
  assign status_o      = out_status_q;
  assign next_offset_o = out_next_q;

endmodule

>>> rtl/dnd_ctrl.sv
// Controller: state machine that sequences loads and the name walk.
module dnd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          op_i,
  input  dnd_pkg::sts_t sts_i,
  output dnd_pkg::cmd_t cmd_o
);

  dnd_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dnd_pkg::S_IDLE: begin
        if (in_valid_i && (op_i == dnd_pkg::OP_PARSE)) begin
          state_d = dnd_pkg::S_HEAD;
        end
      end
      dnd_pkg::S_HEAD: begin
        if (!sts_i.fill_full) begin
          if (!sts_i.pos_lt_len || sts_i.byte_zero) begin
            state_d = dnd_pkg::S_FIN;
          end else if (sts_i.byte_tag == dnd_pkg::LABEL_TAG) begin
            state_d = (sts_i.too_long || sts_i.label_trunc) ? dnd_pkg::S_FIN
                                                            : dnd_pkg::S_COPY;
          end else if (sts_i.byte_tag == dnd_pkg::PTR_TAG) begin
            state_d = sts_i.ptr_trunc ? dnd_pkg::S_FIN : dnd_pkg::S_PTR;
          end else begin
            state_d = dnd_pkg::S_FIN;
          end
        end
      end
      dnd_pkg::S_COPY: begin
        if (!sts_i.fill_full && sts_i.cnt_last) begin
          state_d = dnd_pkg::S_HEAD;
        end
      end
      dnd_pkg::S_PTR: begin
        if (sts_i.target_trunc || sts_i.loop) begin
          state_d = dnd_pkg::S_FIN;
        end else begin
          state_d = dnd_pkg::S_HEAD;
        end
      end
      dnd_pkg::S_FIN: begin
        if (!sts_i.fill_full && sts_i.out_free) begin
          state_d = dnd_pkg::S_IDLE;
        end
      end
      default: state_d = dnd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dnd_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_i == dnd_pkg::OP_PARSE) begin
            cmd_o.start = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      dnd_pkg::S_HEAD: begin
        if (sts_i.fill_full) begin
          cmd_o.flush = sts_i.out_free;
        end else if (!sts_i.pos_lt_len) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = dnd_pkg::ST_TRUNC;
        end else if (sts_i.byte_zero) begin
          // The terminating zero byte belongs to the name.
          cmd_o.push       = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = dnd_pkg::ST_OK;
        end else if (sts_i.byte_tag == dnd_pkg::LABEL_TAG) begin
          if (sts_i.too_long) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = dnd_pkg::ST_LONG;
          end else if (sts_i.label_trunc) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = dnd_pkg::ST_TRUNC;
          end else begin
            cmd_o.label_begin = 1'b1;
          end
        end else if (sts_i.byte_tag == dnd_pkg::PTR_TAG) begin
          if (sts_i.ptr_trunc) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = dnd_pkg::ST_TRUNC;
          end else begin
            cmd_o.ptr_begin = 1'b1;
          end
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = dnd_pkg::ST_RESV;
        end
      end
      dnd_pkg::S_COPY: begin
        if (sts_i.fill_full) begin
          cmd_o.flush = sts_i.out_free;
        end else begin
          cmd_o.push    = 1'b1;
          cmd_o.advance = 1'b1;
        end
      end
      dnd_pkg::S_PTR: begin
        if (sts_i.target_trunc) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = dnd_pkg::ST_TRUNC;
        end else if (sts_i.loop) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = dnd_pkg::ST_LOOP;
        end else begin
          cmd_o.ptr_jump = 1'b1;
        end
      end
      dnd_pkg::S_FIN: begin
        if (sts_i.fill_full) begin
          cmd_o.flush = sts_i.out_free;
        end else begin
          cmd_o.emit_last = sts_i.out_free;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dnd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the DNS name decompressor: directed, random, stall and full-store tests.
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    logic [63:0]      chunk;
    logic [3:0]       nbytes;
    logic             last;
    dnd_pkg::status_e status;
    logic [9:0]       next_off;
  } name_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        op_i = dnd_pkg::OP_LOAD;
  logic [7:0]  packet_byte_i = 8'h00;
  logic        first_byte_i = 1'b0;
  logic [8:0]  start_offset_i = 9'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] name_chunk_o;
  logic [3:0]  chunk_bytes_o;
  logic        last_o;
  logic [2:0]  status_o;
  logic [9:0]  next_offset_o;

  dns_name_decompressor i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .packet_byte_i (packet_byte_i),
    .first_byte_i  (first_byte_i),
    .start_offset_i(start_offset_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .name_chunk_o  (name_chunk_o),
    .chunk_bytes_o (chunk_bytes_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .next_offset_o (next_offset_o)
  );

  // Predictor state: a private copy of the packet store.
  logic [7:0]  shadow_store [dnd_pkg::PACKET_BYTES_DEF];
  int unsigned shadow_len = 0;
  logic [63:0] acc_chunk;
  int unsigned acc_fill;
  int unsigned acc_count;
  name_word_t  pending_chunks [$];

  // Stimulus state.
  logic [7:0]  pkt_bytes [$];
  int unsigned name_starts [$];
  bit          idle_on = 1'b0;
  int unsigned hold_request = 0;
  int unsigned words_sent = 0;
  int unsigned err_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL dns_name_decompressor");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic void emit_word(input int unsigned nb, input logic lst,
                                    input dnd_pkg::status_e st, input int unsigned nxt);
    name_word_t w;
    w.chunk    = acc_chunk;
    w.nbytes   = 4'(nb);
    w.last     = lst;
    w.status   = st;
    w.next_off = 10'(nxt);
    pending_chunks.push_back(w);
    acc_count++;
    acc_chunk = '0;
    acc_fill  = 0;
  endfunction

  function automatic void push_name_byte(input logic [7:0] v);
    acc_chunk = acc_chunk | ({56'd0, v} << (8 * acc_fill));
    acc_fill++;
    if (acc_fill == 8 && acc_count < 31) emit_word(8, 1'b0, dnd_pkg::ST_OK, 0);
  endfunction

  function automatic void finish_name(input dnd_pkg::status_e st, input int unsigned nxt);
    emit_word(acc_fill, 1'b1, st, (st == dnd_pkg::ST_OK) ? nxt : 0);
  endfunction

  // Works out the words that one accepted input word produces.
  function automatic void predict_name_words(input logic op, input logic [7:0] pbyte,
                                             input logic first, input logic [8:0] offset);
    int unsigned pos, n, name_len, prev_len, ret_off;
    bit          ptr_seen, done;
    logic [7:0]  b;
    if (op == dnd_pkg::OP_LOAD) begin
      if (first) shadow_len = 0;
      if (shadow_len < dnd_pkg::PACKET_BYTES_DEF) begin
        shadow_store[shadow_len] = pbyte;
        shadow_len++;
      end
      return;
    end
    pos = offset;
    name_len = 0;
    prev_len = 'h1ff;
    ptr_seen = 1'b0;
    ret_off = 0;
    done = 1'b0;
    acc_chunk = '0;
    acc_fill = 0;
    acc_count = 0;
    while (!done && pos < shadow_len) begin
      b = shadow_store[pos];
      if (b == 8'h00) begin
        push_name_byte(8'h00);
        finish_name(dnd_pkg::ST_OK, ptr_seen ? ret_off : pos + 1);
        done = 1'b1;
      end else begin
        case (b[7:6])
          dnd_pkg::LABEL_TAG: begin
            n = b + 1;
            if (name_len + n > dnd_pkg::MAX_NAME_LEN) begin
              finish_name(dnd_pkg::ST_LONG, 0);
              done = 1'b1;
            end else if (pos + n > shadow_len) begin
              finish_name(dnd_pkg::ST_TRUNC, 0);
              done = 1'b1;
            end else begin
              for (int i = 0; i < n; i++) push_name_byte(shadow_store[pos + i]);
              name_len += n;
              pos += n;
            end
          end
          dnd_pkg::PTR_TAG: begin
            if (pos + 2 > shadow_len) begin
              finish_name(dnd_pkg::ST_TRUNC, 0);
              done = 1'b1;
            end else begin
              if (!ptr_seen) begin
                ptr_seen = 1'b1;
                ret_off = pos + 2;
              end
              pos = {b[5:0], shadow_store[pos + 1]};
              if (pos > shadow_len) begin
                finish_name(dnd_pkg::ST_TRUNC, 0);
                done = 1'b1;
              end else if (prev_len == name_len) begin
                finish_name(dnd_pkg::ST_LOOP, 0);
                done = 1'b1;
              end else begin
                prev_len = name_len;
              end
            end
          end
          default: begin
            finish_name(dnd_pkg::ST_RESV, 0);
            done = 1'b1;
          end
        endcase
      end
    end
    if (!done) finish_name(dnd_pkg::ST_TRUNC, 0);
  endfunction

  // Offers one word and returns at the edge where it is accepted.
  task automatic send_word(input logic op, input logic [7:0] pbyte, input logic first,
                           input logic [8:0] offset);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    packet_byte_i  <= pbyte;
    first_byte_i   <= first;
    start_offset_i <= offset;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_name_words(op, pbyte, first, offset);
    words_sent++;
  endtask

  task automatic send_parse(input int unsigned offset);
    send_word(dnd_pkg::OP_PARSE, 8'($urandom), 1'($urandom), 9'(offset));
  endtask

  task automatic load_packet();
    foreach (pkt_bytes[i]) send_word(dnd_pkg::OP_LOAD, pkt_bytes[i], i == 0, 9'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_chunks.size() != 0) @(posedge clk_i);
  endtask

  function automatic void push_pointer(input int unsigned target);
    pkt_bytes.push_back({2'b11, 6'(target >> 8)});
    pkt_bytes.push_back(8'(target));
  endfunction

  function automatic void push_label(input int unsigned len);
    pkt_bytes.push_back(8'(len));
    repeat (len) pkt_bytes.push_back(8'($urandom));
  endfunction

  // Names made of random labels that end in a zero byte, a pointer to an earlier
  // name, a pointer to their own start, or a stray byte; the tail is sometimes cut.
  function automatic void build_random_packet();
    int unsigned names, labels, r;
    pkt_bytes.delete();
    name_starts.delete();
    names = $urandom_range(2, 5);
    for (int k = 0; k < names; k++) begin
      if (pkt_bytes.size() > 300) break;
      name_starts.push_back(pkt_bytes.size());
      labels = $urandom_range(0, 3);
      repeat (labels) begin
        if ($urandom_range(0, 7) == 0) push_label($urandom_range(13, 63));
        else push_label($urandom_range(1, 12));
      end
      r = $urandom_range(0, 9);
      if (r < 4 || k == 0) pkt_bytes.push_back(8'h00);
      else if (r < 8) push_pointer(name_starts[$urandom_range(0, k - 1)]);
      else if (r == 8) push_pointer(name_starts[k]);
      else pkt_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) if (pkt_bytes.size() > 1) void'(pkt_bytes.pop_back());
    end
  endfunction

  task automatic test_directed_names();
    // Empty store: any start offset is past the end.
    send_parse(0);
    pkt_bytes = {8'h03, 8'h77, 8'h77, 8'h77, 8'h00,   // plain name at 0
                 8'h02, 8'h61, 8'h62, 8'hc0, 8'h00,   // label then pointer at 5
                 8'hc0, 8'h05,                        // bare pointer at 10
                 8'h40,                               // reserved type 01 at 12
                 8'h80,                               // reserved type 10 at 13
                 8'hc0, 8'h0e,                        // pointer to itself at 14
                 8'hc1, 8'hff,                        // target past the end at 16
                 8'h03, 8'h78};                       // label past the end at 18
    load_packet();
    foreach (pkt_bytes[i]) begin
      if (i inside {0, 5, 10, 12, 13, 14, 16, 18}) send_parse(i);
    end
    send_parse(pkt_bytes.size());
    wait_drained();
  endtask

  task automatic test_random_packets();
    int unsigned first_word, parses, r;
    first_word = words_sent;
    while (words_sent - first_word < 220) begin
      build_random_packet();
      load_packet();
      parses = $urandom_range(6, 14);
      repeat (parses) begin
        r = $urandom_range(0, 7);
        if (r < 6) send_parse(name_starts[$urandom_range(0, name_starts.size() - 1)]);
        else if (r == 6) send_parse($urandom_range(0, pkt_bytes.size()));
        else send_parse($urandom_range(0, 511));
      end
    end
  endtask

  // The receiver holds off for a long stretch while parses keep coming.
  task automatic test_output_stall();
    hold_request = 80;
    repeat (24) send_parse(name_starts[$urandom_range(0, name_starts.size() - 1)]);
    wait_drained();
  endtask

  // A full store, one dropped byte, names above offset 255, the longest legal
  // name and one just too long.
  task automatic test_full_store();
    pkt_bytes.delete();
    repeat (3) push_label(63);            // 0: 192 name bytes
    pkt_bytes.push_back(8'h00);
    push_label(63);                       // 193: runs over the limit via pointer
    push_pointer(0);
    push_label(61);                       // 259: exactly the limit via pointer
    push_pointer(0);
    pkt_bytes.push_back(8'h02);           // 323: short label, pointer to 259
    pkt_bytes.push_back(8'h71);
    pkt_bytes.push_back(8'h71);
    push_pointer(259);
    while (pkt_bytes.size() < dnd_pkg::PACKET_BYTES_DEF - 1) pkt_bytes.push_back(8'($urandom));
    pkt_bytes.push_back(8'hc0);           // 511: pointer cut off by the end
    load_packet();
    send_word(dnd_pkg::OP_LOAD, 8'($urandom), 1'b0, 9'($urandom));
    send_parse(0);
    send_parse(193);
    send_parse(259);
    send_parse(323);
    send_parse(511);
    repeat (4) send_parse($urandom_range(0, 511));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_names();
    idle_on = 1'b1;
    test_random_packets();
    test_output_stall();
    idle_on = 1'b0;
    test_full_store();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS dns_name_decompressor");
    end else begin
      $display("FAIL dns_name_decompressor");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold when requested.
  initial begin : sink
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left == 0) begin
        if (hold_request != 0) begin
          stall_left = hold_request;
          hold_request = 0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
          stall_left = $urandom_range(1, 5);
        end
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    name_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chunks.size() == 0) begin
        report_error($sformatf("unexpected word chunk=%h", name_chunk_o));
      end else begin
        want = pending_chunks.pop_front();
        if (name_chunk_o !== want.chunk)
          report_error($sformatf("name_chunk %h, want %h", name_chunk_o, want.chunk));
        if (chunk_bytes_o !== want.nbytes)
          report_error($sformatf("chunk_bytes %0d, want %0d", chunk_bytes_o, want.nbytes));
        if (last_o !== want.last)
          report_error($sformatf("last %b, want %b", last_o, want.last));
        if (status_o !== want.status)
          report_error($sformatf("status %0d, want %0d", status_o, want.status));
        if (next_offset_o !== want.next_off)
          report_error($sformatf("next_offset %0d, want %0d", next_offset_o, want.next_off));
      end
    end
  end

endmodule

>>> files.f
rtl/dnd_pkg.sv
rtl/dnd_dp.sv
rtl/dnd_ctrl.sv
rtl/dns_name_decompressor.sv
test/tb_top.sv
